/* src/tavp_pkg.sv */
// Shared types, register indexes and defaults for the two-axis velocity PID.
`timescale 1ns / 1ps

package tavp_pkg;

    localparam int FRAC_BITS_DEF   = 8;
    localparam int INTEG_WIDTH_DEF = 48;

    localparam int VEL_W   = 16;
    localparam int PILOT_W = 12;
    localparam int ERR_W   = 17;
    localparam int GAIN_W  = 16;
    localparam int LIMIT_W = 15;
    localparam int CMD_W   = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [GAIN_W-1:0]  PROP_GAIN_RST   = 16'd500;
    localparam logic [GAIN_W-1:0]  INTEG_GAIN_RST  = 16'd5;
    localparam logic [GAIN_W-1:0]  DERIV_GAIN_RST  = 16'd300;
    localparam logic [LIMIT_W-1:0] ANGLE_LIMIT_RST = 15'd1500;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PROP_GAIN   = 3'd0,
        CFG_INTEG_GAIN  = 3'd1,
        CFG_DERIV_GAIN  = 3'd2,
        CFG_ANGLE_LIMIT = 3'd3,
        CFG_HOVER_MODE  = 3'd4
    } t_cfg_idx;

    typedef enum logic {
        OP_TICK = 1'b0,
        OP_STOP = 1'b1
    } t_opcode;

    // Gains and limit shared by both axis datapaths.
    typedef struct packed {
        logic [GAIN_W-1:0]  prop;
        logic [GAIN_W-1:0]  integ;
        logic [GAIN_W-1:0]  deriv;
        logic [LIMIT_W-1:0] limit;
    } t_axis_cfg;

endpackage

/* src/tavp_axis.sv */
// One axis of the velocity PID: integrator step, command sum, divide and clamp.
`timescale 1ns / 1ps

module tavp_axis
    import tavp_pkg::*;
#(
    parameter int FRAC_BITS   = FRAC_BITS_DEF,
    parameter int INTEG_WIDTH = INTEG_WIDTH_DEF
) (
    input  t_axis_cfg                      i_cfg,
    input  logic                           i_neg,
    input  logic                           i_hold,
    input  logic signed [ERR_W-1:0]        i_err,
    input  logic signed [VEL_W-1:0]        i_accel,
    input  logic signed [CMD_W-1:0]        i_trim,
    input  logic signed [INTEG_WIDTH-1:0]  i_integ,
    output logic signed [INTEG_WIDTH-1:0]  o_integ,
    output logic signed [CMD_W-1:0]        o_cmd,
    output logic                           o_sat
);

    localparam int PROD_W = GAIN_W + 1 + ERR_W;
    localparam int SW     = ((INTEG_WIDTH > PROD_W) ? INTEG_WIDTH : PROD_W) + 1;
    localparam int TW0    = (SW > (CMD_W + FRAC_BITS)) ? SW : (CMD_W + FRAC_BITS);
    localparam int TW     = TW0 + 3;

    localparam logic signed [SW-1:0] IMAX =
        {{(SW - INTEG_WIDTH + 1){1'b0}}, {(INTEG_WIDTH - 1){1'b1}}};
    localparam logic signed [SW-1:0] IMIN = ~IMAX;

    logic signed [PROD_W-1:0]   step;
    logic signed [PROD_W-1:0]   pterm;
    logic signed [PROD_W-1:0]   dterm;
    logic signed [SW-1:0]       isum;
    logic signed [INTEG_WIDTH-1:0] integ_new;
    logic signed [TW-1:0]       qsum;
    logic signed [TW-1:0]       total;
    logic signed [TW-1:0]       quot;
    logic signed [TW-1:0]       lim;

    assign step  = $signed({1'b0, i_cfg.integ}) * i_err;
    assign pterm = $signed({1'b0, i_cfg.prop}) * i_err;
    assign dterm = $signed({1'b0, i_cfg.deriv}) * i_accel;

    // Integrator saturates at its own width rather than wrapping.
    always_comb begin
        isum = SW'(i_integ) + SW'(step);
        if (i_hold) begin
            integ_new = i_integ;
        end else if (isum > IMAX) begin
            integ_new = IMAX[INTEG_WIDTH-1:0];
        end else if (isum < IMIN) begin
            integ_new = IMIN[INTEG_WIDTH-1:0];
        end else begin
            integ_new = isum[INTEG_WIDTH-1:0];
        end
    end

    assign qsum  = TW'(pterm) + TW'(integ_new) - TW'(dterm);
    assign total = i_neg ? ((TW'(i_trim) <<< FRAC_BITS) - qsum)
                         : ((TW'(i_trim) <<< FRAC_BITS) + qsum);
    assign lim   = TW'($signed({1'b0, i_cfg.limit}));

    // Arithmetic shift floors; bump negative values with a remainder to truncate
    // toward zero.
    always_comb begin
        quot = total >>> FRAC_BITS;
        if (total[TW-1] && (|total[FRAC_BITS-1:0])) begin
            quot = quot + TW'(1);
        end
        o_sat = 1'b0;
        if (quot < -lim) begin
            quot  = -lim;
            o_sat = 1'b1;
        end else if (quot > lim) begin
            quot  = lim;
            o_sat = 1'b1;
        end
    end

    assign o_integ = integ_new;
    assign o_cmd   = quot[CMD_W-1:0];

endmodule

/* src/two_axis_velocity_pid_antiwindup.sv */
// Top level of the two-axis velocity PID with integrator-clamping anti-windup.
// A request is first captured in the input register; its result is then loaded into the
// result register once that register is free to take it.
// Throughput: one request per cycle while the result register is not stalled. The rate
// is set by the single compute stage, which updates the integrators in the same cycle it
// forms the commands. Stop requests advance without a result.
// Reset is synchronous and active low: gains return to defaults, integrators and
// commands to zero, and the trim capture is armed.
`timescale 1ns / 1ps

module two_axis_velocity_pid_antiwindup
    import tavp_pkg::*;
#(
    parameter int FRAC_BITS   = FRAC_BITS_DEF,
    parameter int INTEG_WIDTH = INTEG_WIDTH_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,

    input  logic                        i_cfg_we,
    input  logic [CFG_IDX_W-1:0]        i_cfg_idx,
    input  logic [CFG_DATA_W-1:0]       i_cfg_data,

    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic                        i_opcode,
    input  logic                        i_fresh_result,
    input  logic signed [VEL_W-1:0]     i_meas_vel_x,
    input  logic signed [VEL_W-1:0]     i_meas_vel_y,
    input  logic signed [PILOT_W-1:0]   i_pilot_roll,
    input  logic signed [PILOT_W-1:0]   i_pilot_pitch,
    input  logic signed [VEL_W-1:0]     i_accel_x,
    input  logic signed [VEL_W-1:0]     i_accel_y,
    input  logic signed [CMD_W-1:0]     i_trim_roll,
    input  logic signed [CMD_W-1:0]     i_trim_pitch,
    input  logic signed [CMD_W-1:0]     i_trim_yaw,
    input  logic signed [CMD_W-1:0]     i_heading,

    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic signed [CMD_W-1:0]     o_roll_cmd,
    output logic signed [CMD_W-1:0]     o_pitch_cmd,
    output logic signed [CMD_W-1:0]     o_yaw_cmd,
    output logic                        o_roll_saturated,
    output logic                        o_pitch_saturated
);

    // ------------------------------------------------------------------
    // Configuration registers. Writes must arrive only while the block is idle; the block itself does not enforce this.
    // ------------------------------------------------------------------
    t_axis_cfg r_cfg;
    logic      r_hover_mode;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.prop   <= PROP_GAIN_RST;
            r_cfg.integ  <= INTEG_GAIN_RST;
            r_cfg.deriv  <= DERIV_GAIN_RST;
            r_cfg.limit  <= ANGLE_LIMIT_RST;
            r_hover_mode <= 1'b0;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_PROP_GAIN:   r_cfg.prop   <= i_cfg_data[GAIN_W-1:0];
                CFG_INTEG_GAIN:  r_cfg.integ  <= i_cfg_data[GAIN_W-1:0];
                CFG_DERIV_GAIN:  r_cfg.deriv  <= i_cfg_data[GAIN_W-1:0];
                CFG_ANGLE_LIMIT: r_cfg.limit  <= i_cfg_data[LIMIT_W-1:0];
                CFG_HOVER_MODE:  r_hover_mode <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Input register. A request waits here until the result register can
    // take its result; stop requests never need the result register.
    // ------------------------------------------------------------------
    logic                      r_s1_valid;
    t_opcode                   r_s1_op;
    logic                      r_s1_fresh;
    logic signed [VEL_W-1:0]   r_s1_vel_x;
    logic signed [VEL_W-1:0]   r_s1_vel_y;
    logic signed [PILOT_W-1:0] r_s1_pilot_roll;
    logic signed [PILOT_W-1:0] r_s1_pilot_pitch;
    logic signed [VEL_W-1:0]   r_s1_accel_x;
    logic signed [VEL_W-1:0]   r_s1_accel_y;
    logic signed [CMD_W-1:0]   r_s1_trim_roll;
    logic signed [CMD_W-1:0]   r_s1_trim_pitch;
    logic signed [CMD_W-1:0]   r_s1_trim_yaw;
    logic signed [CMD_W-1:0]   r_s1_heading;

    logic out_free;
    logic s1_is_stop;
    logic s1_adv;
    logic s1_tick_adv;
    logic in_accept;

    assign out_free    = !o_out_valid || !i_out_stall;
    assign s1_is_stop  = (r_s1_op == OP_STOP);
    assign s1_adv      = r_s1_valid && (s1_is_stop || out_free);
    assign s1_tick_adv = s1_adv && !s1_is_stop;
    assign o_in_stall  = r_s1_valid && !s1_adv;
    assign in_accept   = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_accept) begin
            r_s1_valid <= 1'b1;
        end else if (s1_adv) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_s1_op          <= t_opcode'(i_opcode);
            r_s1_fresh       <= i_fresh_result;
            r_s1_vel_x       <= i_meas_vel_x;
            r_s1_vel_y       <= i_meas_vel_y;
            r_s1_pilot_roll  <= i_pilot_roll;
            r_s1_pilot_pitch <= i_pilot_pitch;
            r_s1_accel_x     <= i_accel_x;
            r_s1_accel_y     <= i_accel_y;
            r_s1_trim_roll   <= i_trim_roll;
            r_s1_trim_pitch  <= i_trim_pitch;
            r_s1_trim_yaw    <= i_trim_yaw;
            r_s1_heading     <= i_heading;
        end
    end

    // ------------------------------------------------------------------
    // Controller state. The held commands and flags double as the result
    // register, since every control tick reports exactly those values.
    // ------------------------------------------------------------------
    logic signed [INTEG_WIDTH-1:0] r_integ_x, r_integ_y;
    logic                          r_roll_sat, r_pitch_sat;
    logic                          r_first_pending;
    logic signed [CMD_W-1:0]       r_held_trim_roll, r_held_trim_pitch, r_held_trim_yaw;
    logic signed [CMD_W-1:0]       r_roll_out, r_pitch_out, r_yaw_out;
    logic                          r_out_valid;

    // On the first tick after reset or a stop the trims come straight from
    // the request, so a fresh result in that same tick already uses them.
    logic signed [CMD_W-1:0] eff_trim_roll, eff_trim_pitch, eff_trim_yaw;

    assign eff_trim_roll  = r_first_pending ? r_s1_trim_roll  : r_held_trim_roll;
    assign eff_trim_pitch = r_first_pending ? r_s1_trim_pitch : r_held_trim_pitch;
    assign eff_trim_yaw   = r_first_pending ? r_s1_trim_yaw   : r_held_trim_yaw;

    // Setpoints are ten times the pilot angle, zero in hover. The pitch stick
    // maps to a negative x setpoint.
    logic signed [ERR_W-1:0] pitch_ext, roll_ext;
    logic signed [ERR_W-1:0] spx, spy;
    logic signed [ERR_W-1:0] err_x, err_y;

    assign pitch_ext = ERR_W'(r_s1_pilot_pitch);
    assign roll_ext  = ERR_W'(r_s1_pilot_roll);
    assign spx = r_hover_mode ? '0 : -((pitch_ext <<< 3) + (pitch_ext <<< 1));
    assign spy = r_hover_mode ? '0 :  ((roll_ext  <<< 3) + (roll_ext  <<< 1));
    assign err_x = spx - ERR_W'(r_s1_vel_x);
    assign err_y = spy - ERR_W'(r_s1_vel_y);

    logic signed [INTEG_WIDTH-1:0] integ_x_new, integ_y_new;
    logic signed [CMD_W-1:0]       roll_new, pitch_new;
    logic                          roll_sat_new, pitch_sat_new;

    // Roll: trim + P*ey + integ_y - D*accel_y.
    tavp_axis #(
        .FRAC_BITS   (FRAC_BITS),
        .INTEG_WIDTH (INTEG_WIDTH)
    ) u_axis_roll (
        .i_cfg   (r_cfg),
        .i_neg   (1'b0),
        .i_hold  (r_roll_sat),
        .i_err   (err_y),
        .i_accel (r_s1_accel_y),
        .i_trim  (eff_trim_roll),
        .i_integ (r_integ_y),
        .o_integ (integ_y_new),
        .o_cmd   (roll_new),
        .o_sat   (roll_sat_new)
    );

    // Pitch: trim - (P*ex + integ_x - D*accel_x).
    tavp_axis #(
        .FRAC_BITS   (FRAC_BITS),
        .INTEG_WIDTH (INTEG_WIDTH)
    ) u_axis_pitch (
        .i_cfg   (r_cfg),
        .i_neg   (1'b1),
        .i_hold  (r_pitch_sat),
        .i_err   (err_x),
        .i_accel (r_s1_accel_x),
        .i_trim  (eff_trim_pitch),
        .i_integ (r_integ_x),
        .o_integ (integ_x_new),
        .o_cmd   (pitch_new),
        .o_sat   (pitch_sat_new)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_integ_x         <= '0;
            r_integ_y         <= '0;
            r_roll_sat        <= 1'b0;
            r_pitch_sat       <= 1'b0;
            r_first_pending   <= 1'b1;
            r_held_trim_roll  <= '0;
            r_held_trim_pitch <= '0;
            r_held_trim_yaw   <= '0;
            r_roll_out        <= '0;
            r_pitch_out       <= '0;
            r_yaw_out         <= '0;
        end else if (s1_adv) begin
            if (s1_is_stop) begin
                // Stop clears the integrators and rearms the trim capture;
                // commands and flags are held.
                r_integ_x       <= '0;
                r_integ_y       <= '0;
                r_first_pending <= 1'b1;
            end else begin
                if (r_first_pending) begin
                    r_held_trim_roll  <= r_s1_trim_roll;
                    r_held_trim_pitch <= r_s1_trim_pitch;
                    r_held_trim_yaw   <= r_s1_trim_yaw;
                    // A fresh result in the same tick loads the yaw trim instead.
                    if (!r_s1_fresh) begin
                        r_yaw_out <= r_s1_heading;
                    end
                    r_first_pending   <= 1'b0;
                end
                if (r_s1_fresh) begin
                    r_integ_x   <= integ_x_new;
                    r_integ_y   <= integ_y_new;
                    r_roll_out  <= roll_new;
                    r_pitch_out <= pitch_new;
                    r_yaw_out   <= eff_trim_yaw;
                    r_roll_sat  <= roll_sat_new;
                    r_pitch_sat <= pitch_sat_new;
                end
            end
        end
    end

    // Result valid: set by every control tick, cleared when taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_tick_adv) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_roll_cmd        = r_roll_out;
    assign o_pitch_cmd       = r_pitch_out;
    assign o_yaw_cmd         = r_yaw_out;
    assign o_roll_saturated  = r_roll_sat;
    assign o_pitch_saturated = r_pitch_sat;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------

    // A new result only appears after a control tick left the input register.
    a_out_from_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !$past(o_out_valid && i_out_stall)) |-> $past(s1_tick_adv))
        else $error("result valid without a control tick");

    // A stop request leaves both integrators at zero and the capture armed.
    a_stop_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s1_adv && s1_is_stop) |=> (r_integ_x == '0 && r_integ_y == '0 && r_first_pending))
        else $error("stop did not clear the integrators");

    // Backpressure on the input side only comes from a blocked control tick.
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (r_s1_valid && !s1_is_stop && o_out_valid && i_out_stall))
        else $error("input stalled without a blocked result");

endmodule
